FILE: rtl/core/cwl_pkg.sv
// Shared types and constants for the card whitelist and log engine.
`timescale 1ns / 1ps
`default_nettype none

package cwl_pkg;

    // Request codes
    localparam logic [1:0] REQ_REPLAY = 2'd0;
    localparam logic [1:0] REQ_CHECK  = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_ERASED    = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_BAD_CRC   = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_MAGIC  = 2'd0;
    localparam logic [1:0] REG_OP_ADD = 2'd1;
    localparam logic [1:0] REG_OP_DEL = 2'd2;
    localparam logic [7:0] RST_MAGIC  = 8'h54;
    localparam logic [7:0] RST_OP_ADD = 8'h01;
    localparam logic [7:0] RST_OP_DEL = 8'h02;

    // CRC-16-CCITT over a ten byte record, a digit of two bits per cycle
    localparam int          MSG_BITS  = 80;
    localparam int          CRC_DIGIT = 2;
    localparam int          CRC_STEPS = MSG_BITS / CRC_DIGIT;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  PAD_FILL  = 8'hFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [39:0] card_uid;
        logic [7:0]  rec_magic;
        logic [7:0]  rec_op;
        logic [7:0]  rec_pad;
        logic [15:0] rec_seq;
        logic [15:0] rec_crc;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic        log_write;
        logic [7:0]  log_op;
        logic [15:0] log_seq;
        logic [15:0] log_crc;
        logic [5:0]  card_count;
    } t_res;

    // Table update command
    typedef struct packed {
        logic set;
        logic clr;
    } t_tbl_cmd;

    // Outcome of a table scan
    typedef struct packed {
        logic done;
        logic hit;
        logic has_free;
    } t_scan_flags;

endpackage

`default_nettype wire

FILE: rtl/core/cwl_crc.sv
// Digit-serial CRC-16-CCITT unit over one ten byte record.
`timescale 1ns / 1ps
`default_nettype none

module cwl_crc (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [cwl_pkg::MSG_BITS-1:0] i_msg,
    output logic                              o_done,
    output logic [15:0]                       o_crc
);
    import cwl_pkg::*;

    localparam int CW = $clog2(CRC_STEPS + 1);

    logic [MSG_BITS-1:0] r_msg;
    logic [15:0]         r_crc;
    logic [15:0]         n_crc;
    logic [CW-1:0]       r_cnt;
    logic                r_run;
    logic                r_done;

    // Two message bits per cycle, MSB of each byte first
    always_comb begin
        logic fb;
        n_crc = r_crc;
        for (int k = 0; k < CRC_DIGIT; k++) begin
            fb    = n_crc[15] ^ r_msg[MSG_BITS-1-k];
            n_crc = {n_crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(CRC_STEPS);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift register and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_msg <= i_msg;
            r_crc <= CRC_INIT;
        end else if (r_run) begin
            r_msg <= r_msg << CRC_DIGIT;
            r_crc <= n_crc;
        end
    end

    assign o_done = r_done;
    assign o_crc  = r_crc;

endmodule

`default_nettype wire

FILE: rtl/core/cwl_table.sv
// Whitelist store with valid marks and a one-entry-per-cycle scan.
`timescale 1ns / 1ps
`default_nettype none

module cwl_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDXW        = 5,
    parameter int CNTW        = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [39:0]           i_uid,
    input  wire cwl_pkg::t_tbl_cmd     i_cmd,
    input  wire logic [IDXW-1:0]       i_idx,
    output cwl_pkg::t_scan_flags       o_flags,
    output logic [IDXW-1:0]            o_hit_idx,
    output logic [IDXW-1:0]            o_free_idx,
    output logic [CNTW-1:0]            o_count
);
    import cwl_pkg::*;

    logic [39:0]            mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNTW-1:0]        r_count;
    logic [CNTW-1:0]        r_ptr;
    logic                   r_scan;
    logic                   r_pend;
    logic                   r_done;
    logic                   r_hit;
    logic                   r_free;
    logic [IDXW-1:0]        r_hit_idx;
    logic [IDXW-1:0]        r_free_idx;
    logic [39:0]            r_rd_data;
    logic                   r_rd_vld;
    logic [IDXW-1:0]        r_rd_idx;
    logic                   ptr_live;

    assign ptr_live = r_ptr < CNTW'(TABLE_DEPTH);

    // Store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.set) begin
            mem[i_idx] <= i_uid;
        end
    end

    // Registered read of the entry under the scan pointer
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_ptr[IDXW-1:0]];
        r_rd_vld  <= r_valid[r_ptr[IDXW-1:0]];
        r_rd_idx  <= r_ptr[IDXW-1:0];
    end

    // Scan control, match and free-slot tracking, valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_ptr   <= '0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            r_pend <= r_scan && ptr_live;
            if (i_start) begin
                r_scan <= 1'b1;
                r_ptr  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_scan) begin
                if (ptr_live) begin
                    r_ptr <= r_ptr + CNTW'(1);
                end else if (!r_pend) begin
                    r_scan <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            // lowest valid match and lowest free entry win
            if (r_pend) begin
                if (r_rd_vld && (r_rd_data == i_uid) && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (!r_rd_vld && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
            if (i_cmd.set) begin
                r_valid[i_idx] <= 1'b1;
                r_count        <= r_count + CNTW'(1);
            end else if (i_cmd.clr) begin
                r_valid[i_idx] <= 1'b0;
                r_count        <= r_count - CNTW'(1);
            end
        end
    end

    assign o_flags.done     = r_done;
    assign o_flags.hit      = r_hit;
    assign o_flags.has_free = r_free;
    assign o_hit_idx        = r_hit_idx;
    assign o_free_idx       = r_free_idx;
    assign o_count          = r_count;

endmodule

`default_nettype wire

FILE: rtl/core/card_whitelist_log_engine.sv
// Top level of the card whitelist and log engine.
// Usage: drive a request on i_req and raise start; the transaction is taken
// at a rising edge with start high and busy low. busy stays high until the
// result is produced. Each request gives exactly one result, shown on o_res
// for one cycle with o_res_vld high; the receiver cannot stall it.
// The table scan (one entry per cycle) and the CRC unit (two message bits
// per cycle) run side by side from the accepting edge; the result is
// registered once both have finished. One request is worked on at a time;
// a new one may be started in the cycle the result shows. Configuration:
// i_cfg_we writes register i_cfg_idx (0 record magic, 1 add op code, 2
// delete op code) from the low byte of i_cfg_wdata. The user must write
// only while busy is low; the block itself does not enforce this. Indexes
// beyond the list are ignored.
// Reset (synchronous, active low) clears all valid marks, the sequence,
// the replay-ended flag and the count, and restores the register defaults.
// Entry contents need no clearing: an entry is only compared when valid.
`timescale 1ns / 1ps
`default_nettype none

module card_whitelist_log_engine #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cwl_pkg::t_req i_req,
    output cwl_pkg::t_res      o_res,
    output logic               o_res_vld,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [7:0]    i_cfg_wdata
);
    import cwl_pkg::*;

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state              r_state;
    t_req                r_req;
    t_res                r_res;
    t_res                n_res;
    logic                r_res_vld;
    logic [15:0]         r_last_seq;
    logic [15:0]         n_last_seq;
    logic                r_ended;
    logic                n_ended;
    logic [7:0]          r_cfg_magic;
    logic [7:0]          r_cfg_add;
    logic [7:0]          r_cfg_del;
    logic                r_crc_fin;
    logic                r_scan_fin;

    logic                accept;
    logic                apply;
    logic [15:0]         seq_inc;
    logic [7:0]          live_op;
    logic [MSG_BITS-1:0] crc_msg;
    logic                crc_done;
    logic [15:0]         crc_val;
    t_tbl_cmd            cmd;
    logic [IDXW-1:0]     cmd_idx;
    t_scan_flags         flags;
    logic [IDXW-1:0]     hit_idx;
    logic [IDXW-1:0]     free_idx;
    logic [CNTW-1:0]     count;
    logic [CNTW-1:0]     count_after;
    logic                erased;

    // Record bytes in CRC order: magic, op, id bytes 0..4, pad, seq low, high
    function automatic logic [MSG_BITS-1:0] record_msg(
        input logic [7:0]  magic,
        input logic [7:0]  op,
        input logic [39:0] uid,
        input logic [7:0]  pad,
        input logic [15:0] seq
    );
        return {magic, op, uid[7:0], uid[15:8], uid[23:16], uid[31:24],
                uid[39:32], pad, seq[7:0], seq[15:8]};
    endfunction

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && (r_state == S_IDLE);
    assign seq_inc = r_last_seq + 16'd1;
    assign live_op = (i_req.req_type == REQ_ADD) ? r_cfg_add : r_cfg_del;

    // CRC message: stored record on replay, the record to append otherwise
    assign crc_msg = (i_req.req_type == REQ_REPLAY)
        ? record_msg(i_req.rec_magic, i_req.rec_op, i_req.card_uid,
                     i_req.rec_pad, i_req.rec_seq)
        : record_msg(r_cfg_magic, live_op, i_req.card_uid, PAD_FILL, seq_inc);

    cwl_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_msg   (crc_msg),
        .o_done  (crc_done),
        .o_crc   (crc_val)
    );

    cwl_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDXW        (IDXW),
        .CNTW        (CNTW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_uid      (r_req.card_uid),
        .i_cmd      (cmd),
        .i_idx      (cmd_idx),
        .o_flags    (flags),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx),
        .o_count    (count)
    );

    assign apply  = (r_state == S_WORK) && r_crc_fin && r_scan_fin;
    assign erased = (&r_req.rec_magic) && (&r_req.rec_op) && (&r_req.card_uid)
                 && (&r_req.rec_pad) && (&r_req.rec_seq) && (&r_req.rec_crc);

    // Decide the outcome once both the CRC and the scan are finished
    always_comb begin
        cmd        = '0;
        n_res      = '0;
        n_res.status = ST_OK;
        n_last_seq = r_last_seq;
        n_ended    = r_ended;
        if (apply) begin
            unique case (r_req.req_type)
                REQ_REPLAY: begin
                    priority if (r_ended) begin
                        n_res.status = ST_IGNORED;
                    end else if (erased) begin
                        n_res.status = ST_ERASED;
                        n_ended      = 1'b1;
                    end else if (r_req.rec_magic != r_cfg_magic) begin
                        n_res.status = ST_BAD_MAGIC;
                        n_ended      = 1'b1;
                    end else if (crc_val != r_req.rec_crc) begin
                        n_res.status = ST_BAD_CRC;
                        n_ended      = 1'b1;
                    end else begin
                        if (r_req.rec_seq > r_last_seq) begin
                            n_last_seq = r_req.rec_seq;
                        end
                        priority if (r_req.rec_op == r_cfg_add) begin
                            cmd.set = !flags.hit && flags.has_free;
                        end else if (r_req.rec_op == r_cfg_del) begin
                            cmd.clr = flags.hit;
                        end else begin
                            cmd = '0;
                        end
                    end
                end
                REQ_CHECK: begin
                    n_res.found = flags.hit;
                end
                REQ_ADD: begin
                    cmd.set         = !flags.hit && flags.has_free;
                    n_last_seq      = seq_inc;
                    n_res.log_write = 1'b1;
                    n_res.log_op    = r_cfg_add;
                    n_res.log_seq   = seq_inc;
                    n_res.log_crc   = crc_val;
                end
                REQ_REMOVE: begin
                    if (flags.hit) begin
                        cmd.clr         = 1'b1;
                        n_last_seq      = seq_inc;
                        n_res.log_write = 1'b1;
                        n_res.log_op    = r_cfg_del;
                        n_res.log_seq   = seq_inc;
                        n_res.log_crc   = crc_val;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    n_res.status = ST_OK;
                end
            endcase
        end
        count_after      = count + CNTW'(cmd.set) - CNTW'(cmd.clr);
        n_res.card_count = 6'(count_after);
    end

    assign cmd_idx = cmd.set ? free_idx : hit_idx;

    // Sequencing, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res_vld  <= 1'b0;
            r_last_seq <= '0;
            r_ended    <= 1'b0;
            r_crc_fin  <= 1'b0;
            r_scan_fin <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            if (crc_done) begin
                r_crc_fin <= 1'b1;
            end
            if (flags.done) begin
                r_scan_fin <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= S_WORK;
                        r_crc_fin  <= 1'b0;
                        r_scan_fin <= 1'b0;
                    end
                end
                S_WORK: begin
                    if (apply) begin
                        r_state    <= S_IDLE;
                        r_res_vld  <= 1'b1;
                        r_last_seq <= n_last_seq;
                        r_ended    <= n_ended;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Transaction payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (apply) begin
            r_res <= n_res;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_magic <= RST_MAGIC;
            r_cfg_add   <= RST_OP_ADD;
            r_cfg_del   <= RST_OP_DEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAGIC:  r_cfg_magic <= i_cfg_wdata;
                REG_OP_ADD: r_cfg_add   <= i_cfg_wdata;
                REG_OP_DEL: r_cfg_del   <= i_cfg_wdata;
                default: begin
                    r_cfg_magic <= r_cfg_magic;
                end
            endcase
        end
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

endmodule

`default_nettype wire

FILE: verif/card_whitelist_log_engine_tb.sv
// Self-checking testbench for the card whitelist and log engine.
`timescale 1ns / 1ps

module card_whitelist_log_engine_tb;
    import cwl_pkg::*;

    localparam int          DEPTH        = 32;
    localparam int          POOL         = 40;
    localparam int          ROWS         = 20;
    localparam int          PHASES       = 6;
    localparam int          RAND_ITEMS   = 1800;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam logic [1:0]  REG_SPARE    = 2'd3;     // unmapped index, write is dropped
    localparam logic [7:0]  OP_UNKNOWN   = 8'h77;
    localparam logic [7:0]  BYTE_ONES    = 8'hFF;
    localparam logic [15:0] SEQ_ONES     = 16'hFFFF;
    localparam logic [39:0] UID_ONES     = 40'hFF_FFFF_FFFF;

    // Ways a replay can be brought to its end
    typedef enum int {END_ERASED, END_MAGIC, END_CRC} t_end_kind;

    // One row of the directed stimulus
    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_vector;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_req       i_req       = '0;
    t_res       o_res;
    logic       o_res_vld;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_idx   = '0;
    logic [7:0] i_cfg_wdata = '0;

    // Shadow copy of the whitelist, sequence tracking and registers
    logic [39:0] sh_ids [DEPTH];
    logic        sh_valid [DEPTH];
    logic [15:0] sh_seq;
    logic        sh_ended;
    logic [5:0]  sh_count;
    logic [7:0]  sh_magic;
    logic [7:0]  sh_op_add;
    logic [7:0]  sh_op_del;

    t_res        due_replies [$];
    int          n_errors   = 0;
    int          n_cycles   = 0;
    int unsigned burst_left = 0;

    card_whitelist_log_engine #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_res_vld   (o_res_vld),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // CRC-16-CCITT, one byte, MSB first
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // CRC over magic, op, id bytes 0..4, pad, seq low, seq high
    function automatic logic [15:0] record_crc(logic [7:0] magic, logic [7:0] op,
                                               logic [39:0] uid, logic [7:0] pad,
                                               logic [15:0] seq);
        logic [15:0] c;
        c = CRC_INIT;
        c = crc_byte(c, magic);
        c = crc_byte(c, op);
        for (int i = 0; i < 5; i++)
            c = crc_byte(c, uid[8*i +: 8]);
        c = crc_byte(c, pad);
        c = crc_byte(c, seq[7:0]);
        c = crc_byte(c, seq[15:8]);
        return c;
    endfunction

    // Lowest valid entry holding the id, or -1
    function automatic int find_slot(logic [39:0] uid);
        for (int i = 0; i < DEPTH; i++)
            if (sh_valid[i] && sh_ids[i] == uid)
                return i;
        return -1;
    endfunction

    // Store into the lowest free entry unless present or full
    function automatic void shadow_add(logic [39:0] uid);
        if (find_slot(uid) >= 0)
            return;
        for (int i = 0; i < DEPTH; i++) begin
            if (!sh_valid[i]) begin
                sh_ids[i]   = uid;
                sh_valid[i] = 1'b1;
                sh_count++;
                return;
            end
        end
    endfunction

    function automatic bit shadow_del(logic [39:0] uid);
        int slot;
        slot = find_slot(uid);
        if (slot < 0)
            return 1'b0;
        sh_valid[slot] = 1'b0;
        sh_count--;
        return 1'b1;
    endfunction

    // Applies one request to the shadow state and returns the reply it gives
    function automatic t_res whitelist_apply(t_req r);
        t_res       res;
        logic [7:0] op;
        bit         emit;
        res  = '0;
        op   = '0;
        emit = 1'b0;
        case (r.req_type)
            REQ_REPLAY: begin
                if (sh_ended) begin
                    res.status = ST_IGNORED;
                end else if (r.rec_magic == BYTE_ONES && r.rec_op == BYTE_ONES &&
                             r.card_uid == UID_ONES && r.rec_pad == BYTE_ONES &&
                             r.rec_seq == SEQ_ONES && r.rec_crc == SEQ_ONES) begin
                    res.status = ST_ERASED;
                    sh_ended   = 1'b1;
                end else if (r.rec_magic != sh_magic) begin
                    res.status = ST_BAD_MAGIC;
                    sh_ended   = 1'b1;
                end else if (record_crc(r.rec_magic, r.rec_op, r.card_uid, r.rec_pad,
                                        r.rec_seq) != r.rec_crc) begin
                    res.status = ST_BAD_CRC;
                    sh_ended   = 1'b1;
                end else begin
                    if (r.rec_seq > sh_seq)
                        sh_seq = r.rec_seq;
                    // add wins when both codes are equal
                    if (r.rec_op == sh_op_add)
                        shadow_add(r.card_uid);
                    else if (r.rec_op == sh_op_del)
                        void'(shadow_del(r.card_uid));
                end
            end
            REQ_CHECK: begin
                res.found = (find_slot(r.card_uid) >= 0);
            end
            REQ_ADD: begin
                shadow_add(r.card_uid);
                op   = sh_op_add;
                emit = 1'b1;
            end
            default: begin
                // remove
                op = sh_op_del;
                if (shadow_del(r.card_uid))
                    emit = 1'b1;
                else
                    res.status = ST_NOT_FOUND;
            end
        endcase
        if (emit) begin
            sh_seq        = sh_seq + 16'd1;
            res.log_write = 1'b1;
            res.log_op    = op;
            res.log_seq   = sh_seq;
            res.log_crc   = record_crc(sh_magic, op, r.card_uid, PAD_FILL, sh_seq);
        end
        res.card_count = sh_count;
        return res;
    endfunction

    function automatic t_req mk_req(logic [1:0] kind, logic [39:0] uid, logic [7:0] op,
                                    logic [15:0] seq);
        t_req q;
        q           = '0;
        q.req_type  = kind;
        q.card_uid  = uid;
        q.rec_magic = RST_MAGIC;
        q.rec_op    = op;
        q.rec_pad   = 8'($urandom);
        q.rec_seq   = seq;
        return q;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Drive one transaction, wait for it to be taken, log the reply it owes
    task automatic send_item(t_req r, bit typed, t_res want);
        t_res reply;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        reply = whitelist_apply(r);
        due_replies.push_back(typed ? want : reply);
    endtask

    // Sender bursts: a random run of back-to-back requests, then a random gap
    task automatic pace(bit steady);
        int unsigned gap;
        if (steady)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 10);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Register write, only once every reply has come back
    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        start <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            REG_MAGIC:  sh_magic  = value;
            REG_OP_ADD: sh_op_add = value;
            REG_OP_DEL: sh_op_del = value;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result check, field by field against the oldest outstanding reply
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_res_vld) begin
            if (due_replies.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(o_res), 64'(0));
            end else begin
                want = due_replies.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch("status", 64'(o_res.status), 64'(want.status));
                if (o_res.found !== want.found)
                    report_mismatch("found", 64'(o_res.found), 64'(want.found));
                if (o_res.log_write !== want.log_write)
                    report_mismatch("log_write", 64'(o_res.log_write), 64'(want.log_write));
                if (o_res.log_op !== want.log_op)
                    report_mismatch("log_op", 64'(o_res.log_op), 64'(want.log_op));
                if (o_res.log_seq !== want.log_seq)
                    report_mismatch("log_seq", 64'(o_res.log_seq), 64'(want.log_seq));
                if (o_res.log_crc !== want.log_crc)
                    report_mismatch("log_crc", 64'(o_res.log_crc), 64'(want.log_crc));
                if (o_res.card_count !== want.card_count)
                    report_mismatch("card_count", 64'(o_res.card_count),
                                    64'(want.card_count));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_vector     directed [ROWS];
        logic [39:0] uid_pool [POOL];
        t_req        r;
        t_res        miss;
        t_end_kind   end_kind;
        logic [63:0] wide;
        int unsigned roll;
        int unsigned end_at;
        int unsigned n_total;
        int unsigned n_live;
        int unsigned add_pct;
        int unsigned replay_pct;
        bit          steady;
        bit          was_ended;

        // shadow state as it leaves reset
        for (int i = 0; i < DEPTH; i++) begin
            sh_ids[i]   = '0;
            sh_valid[i] = 1'b0;
        end
        sh_seq    = '0;
        sh_ended  = 1'b0;
        sh_count  = '0;
        sh_magic  = RST_MAGIC;
        sh_op_add = RST_OP_ADD;
        sh_op_del = RST_OP_DEL;

        // id pool, larger than the table so it can fill up
        uid_pool[0] = '0;
        uid_pool[1] = UID_ONES;
        uid_pool[2] = 40'h1;
        uid_pool[3] = 40'hAA_AAAA_AAAA;
        for (int i = 4; i < POOL; i++) begin
            wide = {$urandom, $urandom};
            uid_pool[i] = wide[39:0];
        end

        miss        = '0;
        miss.status = ST_NOT_FOUND;

        // Directed rows; replays get a matching CRC when walked
        directed[0]  = '{mk_req(REQ_CHECK,  40'h0,           8'h00,      16'h0000), 1'b1, '0};
        directed[1]  = '{mk_req(REQ_REMOVE, UID_ONES,        8'h00,      16'h0000), 1'b1, miss};
        directed[2]  = '{mk_req(REQ_CHECK,  UID_ONES,        8'h00,      16'h0000), 1'b1, '0};
        directed[3]  = '{mk_req(REQ_REPLAY, 40'h1,           RST_OP_ADD, 16'h0003), 1'b0, '0};
        directed[4]  = '{mk_req(REQ_REPLAY, UID_ONES,        RST_OP_ADD, SEQ_ONES), 1'b0, '0};
        directed[5]  = '{mk_req(REQ_REPLAY, 40'h55_5555_5555, OP_UNKNOWN, 16'h0010), 1'b0, '0};
        directed[6]  = '{mk_req(REQ_REPLAY, 40'h1,           RST_OP_ADD, 16'h0004), 1'b0, '0};
        directed[7]  = '{mk_req(REQ_ADD,    40'h0,           8'h00,      16'h0000), 1'b0, '0};
        directed[8]  = '{mk_req(REQ_ADD,    40'h0,           8'h00,      16'h0000), 1'b0, '0};
        directed[9]  = '{mk_req(REQ_CHECK,  40'h0,           8'h00,      16'h0000), 1'b0, '0};
        directed[10] = '{mk_req(REQ_CHECK,  UID_ONES,        8'h00,      16'h0000), 1'b0, '0};
        directed[11] = '{mk_req(REQ_REMOVE, 40'h0,           8'h00,      16'h0000), 1'b0, '0};
        directed[12] = '{mk_req(REQ_REMOVE, 40'h0,           8'h00,      16'h0000), 1'b0, '0};
        directed[13] = '{mk_req(REQ_REPLAY, UID_ONES,        RST_OP_DEL, 16'h8000), 1'b0, '0};
        directed[14] = '{mk_req(REQ_REPLAY, 40'h123,         RST_OP_DEL, 16'h0000), 1'b0, '0};
        directed[15] = '{mk_req(REQ_ADD,    40'hAA_AAAA_AAAA, 8'h00,     16'h0000), 1'b0, '0};
        directed[16] = '{mk_req(REQ_REMOVE, 40'h1,           8'h00,      16'h0000), 1'b0, '0};
        directed[17] = '{mk_req(REQ_CHECK,  40'hAA_AAAA_AAAA, 8'h00,     16'h0000), 1'b0, '0};
        directed[18] = '{mk_req(REQ_REPLAY, 40'hAA_AAAA_AAAA, RST_OP_ADD, 16'h7FFF), 1'b0, '0};
        directed[19] = '{mk_req(REQ_CHECK,  40'h1,           8'h00,      16'h0000), 1'b0, '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part, default registers
        for (int i = 0; i < ROWS; i++) begin
            r = directed[i].req;
            if (r.req_type == REQ_REPLAY)
                r.rec_crc = record_crc(r.rec_magic, r.rec_op, r.card_uid, r.rec_pad, r.rec_seq);
            pace(1'b0);
            send_item(r, directed[i].typed, directed[i].want);
        end

        // Random part: replay is ended once, at a random point, in a random way
        n_total  = 0;
        end_at   = $urandom_range(900, 1400);
        end_kind = t_end_kind'($urandom_range(0, 2));
        for (int p = 0; p < PHASES; p++) begin
            steady = 1'b0;
            case (p)
                0: begin
                    write_reg(REG_MAGIC,  8'hFF);
                    write_reg(REG_OP_ADD, 8'h00);
                    write_reg(REG_OP_DEL, 8'hFF);
                    add_pct = 25;
                end
                1: begin
                    // equal codes: add takes precedence on replay
                    write_reg(REG_MAGIC,  8'h00);
                    write_reg(REG_OP_ADD, 8'hFF);
                    write_reg(REG_OP_DEL, 8'hFF);
                    add_pct = 45;
                end
                2: begin
                    write_reg(REG_SPARE,  8'($urandom));
                    write_reg(REG_MAGIC,  8'($urandom));
                    write_reg(REG_OP_ADD, 8'($urandom));
                    write_reg(REG_OP_DEL, 8'($urandom));
                    add_pct = 10;
                end
                3: begin
                    write_reg(REG_MAGIC,  RST_MAGIC);
                    write_reg(REG_OP_ADD, RST_OP_ADD);
                    write_reg(REG_OP_DEL, RST_OP_DEL);
                    add_pct = 45;
                end
                default: begin
                    write_reg(REG_MAGIC,  8'($urandom));
                    write_reg(REG_OP_ADD, 8'($urandom));
                    write_reg(REG_OP_DEL, 8'($urandom));
                    add_pct = 25;
                    steady  = (p == PHASES - 1);
                end
            endcase

            n_live = 0;
            while (n_live < RAND_ITEMS / PHASES) begin
                r           = '0;
                wide        = {$urandom, $urandom};
                r.card_uid  = ($urandom_range(0, 9) == 0) ? wide[39:0]
                                                          : uid_pool[$urandom_range(0, POOL - 1)];
                r.rec_magic = 8'($urandom);
                r.rec_op    = 8'($urandom);
                r.rec_pad   = 8'($urandom);
                r.rec_seq   = 16'($urandom);
                r.rec_crc   = 16'($urandom);
                replay_pct  = sh_ended ? 8 : 30;
                roll        = $urandom_range(0, 99);

                if (n_total == end_at && !sh_ended) begin
                    r.req_type = REQ_REPLAY;
                    case (end_kind)
                        END_ERASED: begin
                            r.rec_magic = BYTE_ONES;
                            r.rec_op    = BYTE_ONES;
                            r.card_uid  = UID_ONES;
                            r.rec_pad   = BYTE_ONES;
                            r.rec_seq   = SEQ_ONES;
                            r.rec_crc   = SEQ_ONES;
                        end
                        END_MAGIC: begin
                            r.rec_magic = sh_magic ^ 8'($urandom_range(1, 255));
                            r.rec_crc   = record_crc(r.rec_magic, r.rec_op, r.card_uid,
                                                     r.rec_pad, r.rec_seq);
                        end
                        default: begin
                            r.rec_magic = sh_magic;
                            r.rec_crc   = record_crc(r.rec_magic, r.rec_op, r.card_uid,
                                                     r.rec_pad, r.rec_seq)
                                          ^ 16'($urandom_range(1, 65535));
                        end
                    endcase
                end else if (roll < replay_pct) begin
                    r.req_type = REQ_REPLAY;
                    // after the end, half the records are plain noise
                    if (!sh_ended || $urandom_range(0, 1) == 0) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 45)
                            r.rec_op = sh_op_add;
                        else if (roll < 80)
                            r.rec_op = sh_op_del;
                        case ($urandom_range(0, 3))
                            0: r.rec_seq = 16'($urandom);
                            1: r.rec_seq = ($urandom_range(0, 1) != 0) ? SEQ_ONES : 16'h0000;
                            default: r.rec_seq = 16'(sh_seq - 16'd20
                                                     + 16'($urandom_range(0, 40)));
                        endcase
                        r.rec_magic = sh_magic;
                        r.rec_crc   = record_crc(r.rec_magic, r.rec_op, r.card_uid,
                                                 r.rec_pad, r.rec_seq);
                    end
                end else if (roll < replay_pct + 20) begin
                    r.req_type = REQ_CHECK;
                end else if (roll < replay_pct + 20 + add_pct) begin
                    r.req_type = REQ_ADD;
                end else begin
                    r.req_type = REQ_REMOVE;
                end

                was_ended = sh_ended;
                pace(steady);
                send_item(r, 1'b0, '0);
                n_total++;
                // replays after the end are only ignored
                if (!(r.req_type == REQ_REPLAY && was_ended))
                    n_live++;
            end
        end

        // Let the last replies drain, then watch for strays
        start <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
